[sv/mscrc_pkg.sv]
// ----------------------------------------------------------------------------
// mscrc_pkg
// Shared types, constants and functions for the Mode S CRC-24 / PPM framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mscrc_pkg;

  localparam int DefaultDataBytes = 11;

  localparam int PosW    = 4;
  localparam int ByteW   = 8;
  localparam int WordW   = 16;
  localparam int KindW   = 2;
  localparam int ParityW = 24;

  localparam logic [ParityW-1:0] CrcPoly      = 24'hFFF409;
  localparam logic [WordW-1:0]   PreambleWord = 16'hA140;

  localparam logic [KindW-1:0] KIND_PREAMBLE = 2'd0;
  localparam logic [KindW-1:0] KIND_DATA     = 2'd1;
  localparam logic [KindW-1:0] KIND_PARITY   = 2'd2;

  // Word being presented on the output, one-hot.
  typedef enum logic [4:0] {
    PH_PRE     = 5'b00001,
    PH_DATA    = 5'b00010,
    PH_PAR_HI  = 5'b00100,
    PH_PAR_MID = 5'b01000,
    PH_PAR_LO  = 5'b10000
  } phase_t;

  // Pulse-position coding: bit 1 -> chips 10, bit 0 -> chips 01.
  function automatic logic [WordW-1:0] ppm_word(input logic [ByteW-1:0] b);
    logic [WordW-1:0] w;
    for (int i = 0; i < ByteW; i++) begin
      w[2*i+1] = b[i];
      w[2*i]   = ~b[i];
    end
    return w;
  endfunction

  // Eight bitwise parity steps, most significant data bit first.
  function automatic logic [ParityW-1:0] crc_byte(input logic [ParityW-1:0] r,
                                                  input logic [ByteW-1:0] b);
    logic [ParityW-1:0] acc;
    logic               fb;
    acc = r;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb  = b[i] ^ acc[ParityW-1];
      acc = {acc[ParityW-2:0], 1'b0};
      if (fb) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

[sv/mode_s_crc_ppm_framer.sv]
// ----------------------------------------------------------------------------
// mode_s_crc_ppm_framer
// Frames Mode S message bytes into PPM chip words with preamble and CRC-24.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, data_byte[7:0]             | in (stall out)
//  output  | out_valid, out_stall, chip_word[15:0],         | out (stall in)
//          | word_kind[1:0], end_of_frame, last             |
//
//  Each input transaction yields one to five output transactions (four at most
//  when DATA_BYTES exceeds one): an optional preamble word, the data word, and on the final byte three parity words.
//  A byte that produces only its data word passes at one per clock unless the
//  output stalls; every extra word holds the input back (output rate is one
//  word per clock when not stalled, set by the single job register that feeds
//  the output port). The first word is presented the cycle after the accept.
//  Reset (rst, synchronous) clears the byte count, the parity register and
//  the job valid flag and word phase; no words are pending after reset.
//  Output stall holds the job register; input is taken in the same cycle the
//  final word of the pending job is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mode_s_crc_ppm_framer
  import mscrc_pkg::*;
#(
  parameter int DATA_BYTES = DefaultDataBytes
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ByteW-1:0]   data_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [WordW-1:0]   chip_word,
  output logic      [KindW-1:0]   word_kind,
  output logic                    end_of_frame,
  output logic                    last
);

  localparam logic [PosW:0] LastCount = (PosW + 1)'(DATA_BYTES);

  // Frame state, advanced as soon as a byte is accepted.
  logic [PosW-1:0]    position;
  logic [PosW-1:0]    position_next;
  logic [ParityW-1:0] parity;
  logic [ParityW-1:0] parity_next;

  // Job register: everything needed to replay the words of one byte.
  logic               job_valid;
  phase_t             phase;
  phase_t             phase_next;
  logic               job_done;
  logic [ByteW-1:0]   job_byte;
  logic [ParityW-1:0] job_parity;

  logic in_take;
  logic out_take;
  logic frame_done;
  logic [ParityW-1:0] crc_new;

  assign out_take = out_valid && !out_stall;

  // Last word of the pending job: data word of a mid-frame byte, or the
  // low parity word.
  always_comb begin
    last = 1'b0;
    unique case (phase)
      PH_DATA:   last = !job_done;
      PH_PAR_LO: last = 1'b1;
      default:   last = 1'b0;
    endcase
  end

  // Take a new byte when nothing is pending or the pending job finishes now.
  assign in_stall = job_valid && !(last && !out_stall);
  assign in_take  = in_valid && !in_stall;

  assign crc_new    = crc_byte(parity, data_byte);
  assign frame_done = ({1'b0, position} + (PosW + 1)'(1)) >= LastCount;

  always_comb begin
    position_next = position;
    parity_next   = parity;
    if (in_take) begin
      if (frame_done) begin
        position_next = '0;
        parity_next   = '0;
      end else begin
        position_next = position + PosW'(1);
        parity_next   = crc_new;
      end
    end
  end

  // Advance the word sequence of the pending job.
  always_comb begin
    phase_next = phase;
    if (in_take) begin
      phase_next = (position == '0) ? PH_PRE : PH_DATA;
    end else if (out_take) begin
      unique case (phase)
        PH_PRE:     phase_next = PH_DATA;
        PH_DATA:    phase_next = PH_PAR_HI;
        PH_PAR_HI:  phase_next = PH_PAR_MID;
        PH_PAR_MID: phase_next = PH_PAR_LO;
        PH_PAR_LO:  phase_next = PH_PRE;
        default:    phase_next = PH_PRE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      parity    <= '0;
      job_valid <= 1'b0;
      phase     <= PH_PRE;
    end else begin
      position <= position_next;
      parity   <= parity_next;
      phase    <= phase_next;
      if (in_take) begin
        job_valid <= 1'b1;
      end else if (out_take && last) begin
        job_valid <= 1'b0;
      end
    end
  end

  // Payload of the job: no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      job_byte   <= data_byte;
      job_done   <= frame_done;
      job_parity <= crc_new;
    end
  end

  // Output word select.
  assign out_valid = job_valid;

  always_comb begin
    chip_word    = PreambleWord;
    word_kind    = KIND_PREAMBLE;
    end_of_frame = 1'b0;
    unique case (phase)
      PH_PRE: begin
        chip_word = PreambleWord;
        word_kind = KIND_PREAMBLE;
      end
      PH_DATA: begin
        chip_word = ppm_word(job_byte);
        word_kind = KIND_DATA;
      end
      PH_PAR_HI: begin
        chip_word = ppm_word(job_parity[23:16]);
        word_kind = KIND_PARITY;
      end
      PH_PAR_MID: begin
        chip_word = ppm_word(job_parity[15:8]);
        word_kind = KIND_PARITY;
      end
      PH_PAR_LO: begin
        chip_word    = ppm_word(job_parity[7:0]);
        word_kind    = KIND_PARITY;
        end_of_frame = 1'b1;
      end
      default: begin
        chip_word = PreambleWord;
        word_kind = KIND_PREAMBLE;
      end
    endcase
  end

  // Assertions
  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> last)
    else $error("end_of_frame without last");

  a_job_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("pending job dropped before its last word");

  a_pre_then_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && word_kind == KIND_PREAMBLE) |=>
      (out_valid && word_kind == KIND_DATA))
    else $error("preamble not followed by data word");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, position} < LastCount))
    else $error("byte count out of range");

  a_frame_start_clear: assert property (@(posedge clk) disable iff (rst)
    (position == '0) |-> (parity == '0))
    else $error("parity not cleared at frame start");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Mode S CRC-24 / PPM framer: a directed table of
// frames, then random message bytes, with random idling on both channels and
// every output word compared against a cycle-free model of the framer.
// ----------------------------------------------------------------------------

module tb_top;
  import mscrc_pkg::*;

  localparam int FrameLen    = DefaultDataBytes;
  localparam int RandomBytes = 200;
  localparam int MaxGap      = 6;
  localparam int DirRows     = 22;
  localparam int ReportLimit = 10;

  // Full 25-bit generator; bit 24 only cancels the bit shifted out on top.
  localparam logic [ParityW:0] GenPoly = 25'h1FFF409;

  // One output transaction as seen on the port.
  typedef struct packed {
    logic [WordW-1:0] chips;
    logic [KindW-1:0] kind;
    logic             eof;
    logic             last;
  } chip_txn_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [ByteW-1:0] data_byte;
  logic             out_valid;
  logic             out_stall;
  logic [WordW-1:0] chip_word;
  logic [KindW-1:0] word_kind;
  logic             end_of_frame;
  logic             last;

  // Framer model state, advanced once per accepted input transaction.
  logic [PosW-1:0]    frame_pos;
  logic [ParityW-1:0] crc_acc;

  // Output words still owed by the framer, oldest first.
  chip_txn_t chip_expect[$];

  int  errors        = 0;
  int  mismatches    = 0;
  int  bytes_sent    = 0;
  int  frames_done   = 0;
  int  words_checked = 0;
  // While set, neither side idles: gives back-to-back stretches.
  bit  calm          = 1'b0;

  // Directed frames, one row per byte: {data byte, expected data-word chips}.
  // A chips value of zero is no legal PPM word, so it marks rows whose data
  // word comes from the model instead of being typed in.
  // Frame one walks the bit extremes; frame two is a real airborne message.
  logic [ByteW+WordW-1:0] dir_table [DirRows] = '{
    {8'h00, 16'h5555}, {8'hFF, 16'hAAAA}, {8'h80, 16'h9555}, {8'h01, 16'h5556},
    {8'hAA, 16'h9999}, {8'h55, 16'h6666}, {8'h7F, 16'h0000}, {8'hFE, 16'h0000},
    {8'h0F, 16'h0000}, {8'hF0, 16'h0000}, {8'hC3, 16'h0000},
    {8'h8D, 16'h0000}, {8'h48, 16'h0000}, {8'h40, 16'h0000}, {8'hD6, 16'h0000},
    {8'h20, 16'h0000}, {8'h2C, 16'h0000}, {8'hC3, 16'h0000}, {8'h71, 16'h0000},
    {8'hC3, 16'h0000}, {8'h2C, 16'h0000}, {8'hE0, 16'h0000}
  };

  mode_s_crc_ppm_framer #(
    .DATA_BYTES(FrameLen)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .chip_word   (chip_word),
    .word_kind   (word_kind),
    .end_of_frame(end_of_frame),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Build the chip word one bit pair at a time, first chip ending up on top.
  function automatic logic [WordW-1:0] ppm_chips(input logic [ByteW-1:0] b);
    logic [WordW-1:0] w;
    w = '0;
    for (int k = ByteW - 1; k >= 0; k--) begin
      w = {w[WordW-3:0], b[k], ~b[k]};
    end
    return w;
  endfunction

  // Run the parity register over one byte, MSB first. After the shift the
  // old top bit sits in bit 24; XOR with the data bit gives the feedback.
  function automatic logic [ParityW-1:0] crc_step(input logic [ParityW-1:0] r,
                                                 input logic [ByteW-1:0]   b);
    logic [ParityW:0] wide;
    wide = {1'b0, r};
    for (int k = ByteW - 1; k >= 0; k--) begin
      wide = {wide[ParityW-1:0], 1'b0};
      if (wide[ParityW] ^ b[k]) begin
        wide = wide ^ GenPoly;
      end
    end
    return wide[ParityW-1:0];
  endfunction

  // Queue the words one accepted byte owes: preamble at frame start, the data
  // word, and on the closing byte the three parity words. A nonzero
  // typed_chips stands in for the modeled data word.
  task automatic frame_byte(input logic [ByteW-1:0] b, input logic [WordW-1:0] typed_chips);
    chip_txn_t words [4];
    int        n;
    n = 0;
    if (frame_pos == '0) begin
      words[n] = '{PreambleWord, KIND_PREAMBLE, 1'b0, 1'b0};
      n++;
    end
    words[n] = '{(typed_chips != '0) ? typed_chips : ppm_chips(b), KIND_DATA, 1'b0, 1'b0};
    n++;
    crc_acc = crc_step(crc_acc, b);
    // Close the frame on its last byte; a count at or past the end also closes.
    if (int'(frame_pos) + 1 >= FrameLen) begin
      words[n]     = '{ppm_chips(crc_acc[23:16]), KIND_PARITY, 1'b0, 1'b0};
      words[n + 1] = '{ppm_chips(crc_acc[15:8]),  KIND_PARITY, 1'b0, 1'b0};
      words[n + 2] = '{ppm_chips(crc_acc[7:0]),   KIND_PARITY, 1'b1, 1'b0};
      n += 3;
      frame_pos = '0;
      crc_acc   = '0;
      frames_done++;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
    words[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      chip_expect.push_back(words[i]);
    end
  endtask

  // Offer one byte after a random gap and hold it until taken. Entered and
  // left at a rising edge; valid is only lowered when a gap follows, so it
  // never gets two assignments in one step.
  task automatic drive_byte(input logic [ByteW-1:0] b, input logic [WordW-1:0] typed_chips);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    // Sample stall mid-cycle: what stands there is what the next edge sees.
    @(negedge clk);
    while (in_stall) @(negedge clk);
    frame_byte(b, typed_chips);
    bytes_sent++;
    @(posedge clk);
    // Flip between idling and back-to-back traffic now and then.
    if ($urandom_range(0, 31) == 0) calm = ~calm;
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      default: begin
        return ByteW'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic void log_mismatch(input string what, input chip_txn_t got,
                                       input chip_txn_t want);
    errors++;
    if (mismatches < ReportLimit) begin
      $display("[%0t] %s: got chips=%h kind=%0d eof=%b last=%b, want chips=%h kind=%0d eof=%b last=%b",
               $time, what, got.chips, got.kind, got.eof, got.last,
               want.chips, want.kind, want.eof, want.last);
    end
    mismatches++;
  endfunction

  // Stimulus: reset, directed table, random bytes, then drain and report.
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= '0;
    frame_pos = '0;
    crc_acc   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DirRows; r++) begin
      drive_byte(dir_table[r][ByteW+WordW-1:WordW], dir_table[r][WordW-1:0]);
    end
    for (int i = 0; i < RandomBytes; i++) begin
      drive_byte(pick_byte(), '0);
    end
    in_valid <= 1'b0;

    // Drain what is owed, then keep watching so a stray late word is caught.
    while (chip_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Framed %0d bytes into %0d complete frames; %0d output words compared.",
             bytes_sent, frames_done, words_checked);
    if (errors == 0 && chip_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Output side: random stall per word, then check each transaction as it is
  // taken against the oldest queued word.
  initial begin
    chip_txn_t got;
    chip_txn_t want;
    int        hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, MaxGap);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (out_valid !== 1'b1) @(negedge clk);
      got = '{chip_word, word_kind, end_of_frame, last};
      if (chip_expect.size() == 0) begin
        log_mismatch("unexpected word", got, '0);
      end else begin
        want = chip_expect.pop_front();
        if (got !== want) begin
          log_mismatch("word mismatch", got, want);
        end
      end
      words_checked++;
      @(posedge clk);
    end
  end

endmodule
